[design/rct_pkg.sv]
// Shared types and constants for the refraction container tracker.
package rct_pkg;

  // Unsigned Q4.12 index value for 1.0 (vacuum / empty list)
  localparam logic [15:0] IndexOne = 16'd4096;

  // Input request: one sorted intersection of a ray
  typedef struct packed {
    logic [15:0] object_id;
    logic [15:0] object_index;
    logic        is_hit;
    logic        last;
  } in_req_t;

  // Output request: indices across the shaded surface
  typedef struct packed {
    logic [15:0] n_from;
    logic [15:0] n_to;
    logic        overflow;
  } out_req_t;

  // One list entry held by a cell
  typedef struct packed {
    logic        valid;
    logic [15:0] id;
    logic [15:0] index;
  } entry_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic        advance;
    logic        remove;
    logic        append;
    logic        clear;
    logic [15:0] id;
    logic [15:0] index;
  } cell_ctrl_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

endpackage

[design/refraction_container_tracker.sv]
// Top level: sequencer, output register and the chain of container cells.
// Flow: an accepted request is held in the item register; its result is registered in the output register.
// One request at a time: the accept/execute sequencer around the cell chain takes no new request
// until execute ends; a hit waits in execute while the output register is full.
// Reset: asynchronous active-low; list, overflow flag, sequencer and output valid clear.
module refraction_container_tracker #(
  parameter int MAX_NESTING = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rct_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rct_pkg::out_req_t out_req_o
);

  rct_pkg::state_e     state_q, state_d;
  rct_pkg::in_req_t    item_q;
  rct_pkg::out_req_t   out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic                ovf_q, ovf_d;
  rct_pkg::cell_ctrl_t ctrl;

  rct_pkg::entry_t           ent [MAX_NESTING];
  logic [MAX_NESTING-1:0]    valid_vec;
  logic [MAX_NESTING-1:0]    match_vec;
  logic [MAX_NESTING-1:0]    top_hot;
  logic [MAX_NESTING-1:0]    sec_hot;
  logic [MAX_NESTING:0]      found_chain;

  logic        accept, advance, out_free;
  logic        any_found, full, empty, has_second, match_top;
  logic [15:0] top_index, sec_index, n_from, n_to;

  assign in_ready_o = (state_q == rct_pkg::S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign out_free   = !out_valid_q | out_ready_i;
  assign advance    = (state_q == rct_pkg::S_EXEC) & (!item_q.is_hit | out_free);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rct_pkg::S_IDLE: if (accept)  state_d = rct_pkg::S_EXEC;
      rct_pkg::S_EXEC: if (advance) state_d = rct_pkg::S_IDLE;
      default:                      state_d = rct_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rct_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_req_i;
    end
  end

  // Cell chain
  assign found_chain[0] = 1'b0;
  assign any_found      = found_chain[MAX_NESTING];
  assign full           = valid_vec[MAX_NESTING-1];
  assign empty          = !valid_vec[0];

  assign ctrl = '{advance: advance,
                  remove:  any_found,
                  append:  !any_found & !full,
                  clear:   item_q.last,
                  id:      item_q.object_id,
                  index:   item_q.object_index};

  for (genvar k = 0; k < MAX_NESTING; k++) begin : g_cell
    rct_pkg::entry_t nbr;
    logic            prev_valid;

    if (k == MAX_NESTING - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_body
      assign nbr = ent[k+1];
    end

    if (k == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = ent[k-1].valid;
    end

    rct_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .nbr_i       (nbr),
      .prev_valid_i(prev_valid),
      .found_i     (found_chain[k]),
      .found_o     (found_chain[k+1]),
      .match_o     (match_vec[k]),
      .entry_o     (ent[k])
    );

    assign valid_vec[k] = ent[k].valid;
  end

  // Top and second-from-top selects over the thermometer of valid bits
  always_comb begin
    top_hot   = '0;
    sec_hot   = '0;
    top_index = '0;
    sec_index = '0;
    for (int k = 0; k < MAX_NESTING; k++) begin
      if (k == MAX_NESTING - 1) begin
        top_hot[k] = valid_vec[k];
      end else begin
        top_hot[k] = valid_vec[k] & !valid_vec[k+1];
      end
    end
    for (int k = 0; k < MAX_NESTING - 1; k++) begin
      sec_hot[k] = top_hot[k+1];
    end
    for (int k = 0; k < MAX_NESTING; k++) begin
      top_index = top_index | ({16{top_hot[k]}} & ent[k].index);
      sec_index = sec_index | ({16{sec_hot[k]}} & ent[k].index);
    end
  end

  assign has_second = |sec_hot;
  assign match_top  = |(match_vec & top_hot);
  assign n_from     = empty ? rct_pkg::IndexOne : top_index;

  // Index after the toggle
  always_comb begin
    priority if (any_found) begin
      if (match_top) begin
        n_to = has_second ? sec_index : rct_pkg::IndexOne;
      end else begin
        n_to = n_from;
      end
    end else if (!full) begin
      n_to = item_q.object_index;
    end else begin
      n_to = n_from;
    end
  end

  // Sticky overflow, cleared at the end of a ray
  always_comb begin
    ovf_d = ovf_q;
    if (advance) begin
      ovf_d = item_q.last ? 1'b0 : (ovf_q | (!any_found & full));
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance && item_q.is_hit) begin
      out_valid_d = 1'b1;
      out_d       = '{n_from: n_from, n_to: n_to, overflow: ovf_q | (!any_found & full)};
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

`ifndef SYNTH
  // List occupancy is always a contiguous run from the head
  a_thermometer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("container list has a hole");

  // Execute returns to idle on the following cycle unless a hit waits on the output register
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rct_pkg::S_EXEC) && (!item_q.is_hit || out_free)
    |=> state_q == rct_pkg::S_IDLE)
    else $error("execute did not complete");

  // The end of a ray leaves an empty list and a clear overflow flag
  a_ray_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item_q.last |=> !valid_vec[0] && !ovf_q)
    else $error("list not cleared after last intersection");

  // A result is produced only by a hit that advances
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && item_q.is_hit))
    else $error("result without a hit request");

  a_state_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");
`endif

endmodule

[design/rct_cell.sv]
// One container list cell: holds one entry, compares, clears, shifts or appends.
module rct_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rct_pkg::cell_ctrl_t ctrl_i,
  input  rct_pkg::entry_t    nbr_i,        // entry of the next cell toward the tail
  input  logic               prev_valid_i, // previous cell holds an entry
  input  logic               found_i,      // a match exists at a lower position
  output logic               found_o,
  output logic               match_o,
  output rct_pkg::entry_t    entry_o
);

  logic        valid_q, valid_d;
  logic [15:0] id_q, id_d;
  logic [15:0] index_q, index_d;
  logic        kill;

  // Compare and first-match chain
  assign match_o = valid_q & (id_q == ctrl_i.id);
  assign kill    = found_i | match_o;
  assign found_o = kill;

  // Next entry: clear, compact from the neighbor, or take the new object
  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    index_d = index_q;
    if (ctrl_i.advance) begin
      priority if (ctrl_i.clear) begin
        valid_d = 1'b0;
      end else if (ctrl_i.remove && kill) begin
        valid_d = nbr_i.valid;
        id_d    = nbr_i.id;
        index_d = nbr_i.index;
      end else if (ctrl_i.append && prev_valid_i && !valid_q) begin
        valid_d = 1'b1;
        id_d    = ctrl_i.id;
        index_d = ctrl_i.index;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    index_q <= index_d;
  end

  assign entry_o = '{valid: valid_q, id: id_q, index: index_q};

endmodule
